### sv/hsfd_pkg.sv
// Shared types, constants and helper functions for the humidity sensor frame decoder.
// Used by hsfd_front, hsfd_queue, hsfd_back and the top level. No dependencies.
package hsfd_pkg;

  // CRC-8 settings, MSB first, no final xor
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TEMP_CRC = 2'd1;
  localparam logic [1:0] ST_HUM_CRC  = 2'd2;

  // Scaling: value = floor(raw * SCALE / 65535) - OFFSET
  localparam int RAW_W  = 16;
  localparam int Q_W    = 15;  // quotient width, max 17500
  localparam int PROD_W = 31;  // 16-bit raw times 15-bit scale
  localparam logic [Q_W-1:0]    T_SCALE  = 15'd17500;
  localparam logic [Q_W-1:0]    H_SCALE  = 15'd12500;
  localparam logic [Q_W-1:0]    T_OFFSET = 15'd4500;
  localparam logic [Q_W-1:0]    H_OFFSET = 15'd600;
  localparam logic [13:0]       H_MAX    = 14'd10000;
  localparam logic [RAW_W:0]    DIV_CONST = 17'd65535;

  // One decoded frame handed from front to back
  typedef struct packed {
    logic [RAW_W-1:0] raw_temp;
    logic [RAW_W-1:0] raw_hum;
    logic [1:0]       status;
  } frame_rec_t;

  // Fold one byte into the running CRC, one bit per step
  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // floor(p / 65535): estimate with p >> 16, then one correction step
  function automatic logic [Q_W-1:0] div65535(input logic [PROD_W-1:0] p);
    logic [Q_W-1:0] q0;
    logic [RAW_W:0] r0;
    q0 = p[PROD_W-1:RAW_W];
    r0 = {1'b0, p[RAW_W-1:0]} + {2'b00, q0};
    return (r0 >= DIV_CONST) ? q0 + 15'd1 : q0;
  endfunction

endpackage

### sv/hsfd_front.sv
// Front end: assembles the six-byte frame and checks both CRC-8 fields.
// Depends on hsfd_pkg. Pushes one frame_rec_t per completed frame.
module hsfd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_fire,   // byte beat accepted
  input  logic [7:0]          data_byte,
  input  logic                frame_start,
  output logic                push,
  output hsfd_pkg::frame_rec_t push_rec
);

  // Byte positions within the frame
  localparam logic [2:0] POS_T_HI  = 3'd0;
  localparam logic [2:0] POS_T_LO  = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_HI  = 3'd3;
  localparam logic [2:0] POS_H_LO  = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  logic [2:0]  pos_r, pos_nxt, pos_eff;
  logic [7:0]  crc_r, crc_nxt, crc_eff;
  logic [15:0] raw_t_r, raw_t_nxt;
  logic [15:0] raw_h_r, raw_h_nxt;
  logic        t_ok_r, t_ok_nxt;
  logic        restart;

  // Frame start or an unused position restarts the frame
  assign restart = frame_start || (pos_r > POS_H_CRC);
  assign pos_eff = restart ? POS_T_HI : pos_r;
  assign crc_eff = restart ? hsfd_pkg::CRC_INIT : crc_r;

  // Per-byte update
  always_comb begin
    pos_nxt   = pos_eff + 3'd1;
    crc_nxt   = crc_eff;
    raw_t_nxt = raw_t_r;
    raw_h_nxt = raw_h_r;
    t_ok_nxt  = t_ok_r;
    push      = 1'b0;
    push_rec.raw_temp = raw_t_r;
    push_rec.raw_hum  = raw_h_r;
    if (!t_ok_r) begin
      push_rec.status = hsfd_pkg::ST_TEMP_CRC;
    end else if (crc_eff != data_byte) begin
      push_rec.status = hsfd_pkg::ST_HUM_CRC;
    end else begin
      push_rec.status = hsfd_pkg::ST_OK;
    end
    case (pos_eff)
      POS_T_HI: begin
        raw_t_nxt = {data_byte, 8'h00};
        crc_nxt   = hsfd_pkg::crc_fold(crc_eff, data_byte);
      end
      POS_T_LO: begin
        raw_t_nxt = {raw_t_r[15:8], data_byte};
        crc_nxt   = hsfd_pkg::crc_fold(crc_eff, data_byte);
      end
      POS_T_CRC: begin
        t_ok_nxt = (crc_eff == data_byte);
        crc_nxt  = hsfd_pkg::CRC_INIT;
      end
      POS_H_HI: begin
        raw_h_nxt = {data_byte, 8'h00};
        crc_nxt   = hsfd_pkg::crc_fold(crc_eff, data_byte);
      end
      POS_H_LO: begin
        raw_h_nxt = {raw_h_r[15:8], data_byte};
        crc_nxt   = hsfd_pkg::crc_fold(crc_eff, data_byte);
      end
      default: begin
        // last byte: hand the frame to the back end
        push    = byte_fire;
        crc_nxt = hsfd_pkg::CRC_INIT;
        pos_nxt = POS_T_HI;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_T_HI;
      crc_r   <= hsfd_pkg::CRC_INIT;
      raw_t_r <= '0;
      raw_h_r <= '0;
      t_ok_r  <= 1'b0;
    end else if (byte_fire) begin
      pos_r   <= pos_nxt;
      crc_r   <= crc_nxt;
      raw_t_r <= raw_t_nxt;
      raw_h_r <= raw_h_nxt;
      t_ok_r  <= t_ok_nxt;
    end
  end

endmodule

### sv/hsfd_queue.sv
// Short FIFO of decoded frames between the front and back ends.
// Depends on hsfd_pkg for the frame_rec_t entry type.
module hsfd_queue #(
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  hsfd_pkg::frame_rec_t push_rec,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output hsfd_pkg::frame_rec_t head_rec
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hsfd_pkg::frame_rec_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_rec  = mem[rd_ptr_r];

  // Occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_rec;
    end
  end

  // Pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

endmodule

### sv/hsfd_back.sv
// Back end: scales raw readings to hundredths in two stages and holds the result beat.
// Depends on hsfd_pkg. Stage one multiplies, stage two divides by 65535, offsets and clamps.
module hsfd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rec_valid,
  input  hsfd_pkg::frame_rec_t rec,
  output logic                 rec_pop,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic [14:0]          res_temp,
  output logic [13:0]          res_hum,
  output logic [1:0]           res_status
);

  logic                             s1_valid_r;
  logic [hsfd_pkg::PROD_W-1:0]      s1_prod_t_r, s1_prod_h_r;
  logic [1:0]                       s1_status_r;
  logic                             s1_adv, s2_load;
  logic [hsfd_pkg::Q_W-1:0]         q_t, q_h, h_diff;
  logic [14:0]                      temp_nxt;
  logic [13:0]                      hum_nxt;
  logic                             out_valid_r;
  logic [14:0]                      out_temp_r;
  logic [13:0]                      out_hum_r;
  logic [1:0]                       out_status_r;

  // Handshake through the two stages
  assign s2_load = !out_valid_r || res_ready;
  assign s1_adv  = s1_valid_r && s2_load;
  assign rec_pop = rec_valid && (!s1_valid_r || s2_load);

  // Stage one: products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!s1_valid_r || s2_load) begin
      s1_valid_r <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      s1_prod_t_r <= hsfd_pkg::PROD_W'(rec.raw_temp) * hsfd_pkg::PROD_W'(hsfd_pkg::T_SCALE);
      s1_prod_h_r <= hsfd_pkg::PROD_W'(rec.raw_hum) * hsfd_pkg::PROD_W'(hsfd_pkg::H_SCALE);
      s1_status_r <= rec.status;
    end
  end

  // Stage two: quotient, offset and humidity clamp
  assign q_t    = hsfd_pkg::div65535(s1_prod_t_r);
  assign q_h    = hsfd_pkg::div65535(s1_prod_h_r);
  assign h_diff = q_h - hsfd_pkg::H_OFFSET;

  always_comb begin
    temp_nxt = '0;
    hum_nxt  = '0;
    if (s1_status_r == hsfd_pkg::ST_OK) begin
      temp_nxt = q_t - hsfd_pkg::T_OFFSET;
      if (q_h < hsfd_pkg::H_OFFSET) begin
        hum_nxt = '0;
      end else if (h_diff > {1'b0, hsfd_pkg::H_MAX}) begin
        hum_nxt = hsfd_pkg::H_MAX;
      end else begin
        hum_nxt = h_diff[13:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_temp_r   <= temp_nxt;
      out_hum_r    <= hum_nxt;
      out_status_r <= s1_status_r;
    end
  end

  assign res_valid  = out_valid_r;
  assign res_temp   = out_temp_r;
  assign res_hum    = out_hum_r;
  assign res_status = out_status_r;

endmodule

### sv/humidity_sensor_frame_decoder_unit.sv
// A frame's sixth accepted byte beat pushes it into the frame queue; it is then registered in
// stage one and the output register. Throughput: one byte beat per cycle unless the queue is
// full; the multiply and divide back end takes one frame per cycle unless out_tready stalls.
// Reset: synchronous active-low rst_n clears byte position, CRC, queue and valid flags.
// Top level of the humidity sensor frame decoder; depends on hsfd_pkg,
// hsfd_front, hsfd_queue and hsfd_back.
module humidity_sensor_frame_decoder_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [14:0] temperature_centi, [28:15] humidity_centi, pad
  output logic [1:0]  out_tuser   // [1:0] status
);

  logic                 byte_fire;
  logic                 push, q_full, q_not_empty, pop;
  hsfd_pkg::frame_rec_t push_rec, head_rec;
  logic [14:0]          res_temp;
  logic [13:0]          res_hum;

  assign in_tready = !q_full;
  assign byte_fire = in_tvalid && in_tready;

  // Byte assembly and CRC check
  hsfd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_fire   (byte_fire),
    .data_byte   (in_tdata),
    .frame_start (in_tuser),
    .push        (push),
    .push_rec    (push_rec)
  );

  // Frame queue
  hsfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (push_rec),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head_rec  (head_rec)
  );

  // Scaling and output beat
  hsfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rec_valid  (q_not_empty),
    .rec        (head_rec),
    .rec_pop    (pop),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_temp   (res_temp),
    .res_hum    (res_hum),
    .res_status (out_tuser)
  );

  assign out_tdata = {3'b000, res_hum, res_temp};

endmodule
